// ===== design/soa_pkg.sv =====
// ----------------------------------------------------------------------------
// Slab object allocator package
// Shared types and codes: commands, status codes, slab list classes, register
// indices and the one-hot sequencer states.
// ----------------------------------------------------------------------------
package soa_pkg;

	typedef enum logic [1:0] {
		CMD_ALLOC  = 2'd0,
		CMD_FREE   = 2'd1,
		CMD_SHRINK = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_NO_SLOT  = 2'd1,
		STS_NOT_FOUND = 2'd2,
		STS_SPARE    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CLS_UNUSED  = 2'd0,
		CLS_EMPTY   = 2'd1,
		CLS_PARTIAL = 2'd2,
		CLS_FULL    = 2'd3
	} slab_class_t;

	typedef enum logic [1:0] {
		REG_OBJECTS_PER_SLAB = 2'd0,
		REG_OBJECT_SIZE      = 2'd1,
		REG_COLOUR_COUNT     = 2'd2,
		REG_COLOUR_STEP      = 2'd3
	} reg_index_t;

	typedef enum logic [11:0] {
		ST_IDLE   = 12'b000000000001,
		ST_SCAN   = 12'b000000000010,
		ST_PICK   = 12'b000000000100,
		ST_COLOUR = 12'b000000001000,
		ST_SETOFF = 12'b000000010000,
		ST_FILL   = 12'b000000100000,
		ST_LOADR  = 12'b000001000000,
		ST_READ   = 12'b000010000000,
		ST_UPD    = 12'b000100000000,
		ST_OFFS   = 12'b001000000000,
		ST_FREE   = 12'b010000000000,
		ST_SHRINK = 12'b100000000000
	} state_t;

	localparam logic [9:0] CHAIN_END = 10'h3FF;

endpackage

// ===== design/slab_object_allocator.sv =====
// ----------------------------------------------------------------------------
// Slab object allocator
// Fixed pool of slab slots with per-slab free-index chains, list classes,
// listing stamps and cache colouring, run by a small multi-cycle sequencer.
// ----------------------------------------------------------------------------
// A command enters on the s_ stream and its single result leaves on the m_
// stream through an output register, so the next command can be taken while
// the previous result still waits. The block handles one command at a time
// and s_tready is low while it works. An allocate scans every slab slot, one
// slot per cycle through a shared age comparator, then picks the slab, loads
// the chain head, reads the chain memory, forms the byte offset on the shared
// multiplier, adds the colour offset and loads the output register. An
// allocate that opens a new slab first forms its colour offset and then
// writes the free chain of the new slab one link per cycle through the
// single chain memory port. A shrink walks every slab slot in turn. The next
// command is taken in the cycle after the result is loaded, and the load
// waits while the output register still holds an unaccepted result.
// Configuration writes are always accepted and must only be issued while
// the block is idle.
module slab_object_allocator #(
	parameter int SLAB_SLOTS  = 16,
	parameter int MAX_OBJECTS = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	// Command stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [3:0] slot_in, [12:4] index_in, [15:13] zero
	input  logic [1:0]  s_tuser,   // [1:0] command
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [3:0] slot_out, [12:4] index_out,
	                               // [34:13] byte_offset, [39:35] released_slabs,
	                               // [53:40] active_objects, [55:54] zero
	output logic [1:0]  m_tuser,   // [1:0] status
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	localparam int SW = (SLAB_SLOTS > 1) ? $clog2(SLAB_SLOTS) : 1;
	localparam int IW = $clog2(MAX_OBJECTS);
	localparam int DEPTH = SLAB_SLOTS * MAX_OBJECTS;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [SW-1:0] LAST_SLOT = SW'(SLAB_SLOTS - 1);
	localparam logic [19:0] MAX_W = 20'(MAX_OBJECTS);
	localparam logic [8:0] SLOTS_W = 9'(SLAB_SLOTS);
	localparam logic [9:0] END_IDX = 10'(int'(soa_pkg::CHAIN_END) % MAX_OBJECTS);

	// Configuration registers.
	logic [9:0]  objs_q;
	logic [12:0] osize_q;
	logic [6:0]  ccount_q;
	logic [12:0] cstep_q;

	// Per-slot state.
	logic [9:0]                 head_q   [SLAB_SLOTS];
	logic [9:0]                 used_q   [SLAB_SLOTS];
	soa_pkg::slab_class_t       class_q  [SLAB_SLOTS];
	logic [15:0]                lstamp_q [SLAB_SLOTS];
	logic [17:0]                coff_q   [SLAB_SLOTS];
	logic [9:0]                 chain_mem [DEPTH];

	logic [15:0] stamp_q;
	logic [6:0]  ncolour_q;
	logic [13:0] active_q;

	soa_pkg::state_t state_q;
	soa_pkg::cmd_t   cmd_q;
	logic [SW-1:0]   k_q;
	logic [SW-1:0]   s_q;
	logic            bad_slot_q;
	logic [8:0]      idx_in_q;
	logic            fresh_q;
	logic            pfound_q, efound_q, ufound_q;
	logic [SW-1:0]   pslot_q, eslot_q, uslot_q;
	logic [15:0]     page_q, eage_q;
	logic [9:0]      fill_q;
	logic [9:0]      rem_q;
	logic [9:0]      rdata_q;
	logic [21:0]     prod_q;

	// Result being built, then the output register.
	soa_pkg::status_t res_sts_q;
	logic [3:0]       res_slot_q;
	logic [8:0]       res_idx_q;
	logic [21:0]      res_off_q;
	logic [4:0]       res_rel_q;
	logic             finish_q;
	logic             out_valid_q;
	soa_pkg::status_t out_sts_q;
	logic [53:0]      out_data_q;

	// Effective objects per slab.
	logic [9:0] n;
	always_comb begin
		if (objs_q == 10'd0) begin
			n = 10'd1;
		end else if (objs_q > 10'(MAX_OBJECTS)) begin
			n = 10'(MAX_OBJECTS);
		end else begin
			n = objs_q;
		end
	end

	// One slot is looked at per cycle: the scan pointer while walking, else
	// the chosen slot.
	logic [SW-1:0] rd_slot;
	soa_pkg::slab_class_t cls;
	logic [9:0]  used;
	logic [15:0] age;
	assign rd_slot = (state_q == soa_pkg::ST_SCAN || state_q == soa_pkg::ST_SHRINK) ? k_q : s_q;
	assign cls  = class_q[rd_slot];
	assign used = used_q[rd_slot];
	assign age  = stamp_q - lstamp_q[rd_slot];

	// Shared compare unit: age against the best of its class while scanning.
	logic [19:0] cmp_a, cmp_b;
	logic        cmp_lt;
	always_comb begin
		cmp_a = {4'd0, age};
		cmp_b = (cls == soa_pkg::CLS_PARTIAL) ? {4'd0, page_q} : {4'd0, eage_q};
	end
	assign cmp_lt = cmp_a < cmp_b;

	// Shared multiplier: colour offset or object byte offset.
	logic [8:0]  mul_a;
	logic [12:0] mul_b;
	logic [21:0] mul_p;
	always_comb begin
		if (state_q == soa_pkg::ST_COLOUR) begin
			mul_a = {2'd0, ncolour_q};
			mul_b = cstep_q;
		end else begin
			mul_a = rem_q[8:0];
			mul_b = osize_q;
		end
	end
	assign mul_p = 22'(mul_a) * 22'(mul_b);

	// Chain memory addressing.
	logic [AW-1:0] base;
	logic [AW-1:0] wr_addr, rd_addr;
	logic          wr_en;
	logic [9:0]    wr_data;
	logic          free_ok;
	assign base = AW'(s_q) * AW'(MAX_OBJECTS);
	assign rd_addr = base + AW'(rem_q[IW-1:0]);
	assign free_ok = !bad_slot_q && cls != soa_pkg::CLS_UNUSED &&
		{1'b0, idx_in_q} < n && used != 10'd0;
	always_comb begin
		if (state_q == soa_pkg::ST_FILL) begin
			wr_en   = 1'b1;
			wr_addr = base + AW'(fill_q[IW-1:0]);
			wr_data = (fill_q == n - 10'd1) ? soa_pkg::CHAIN_END : fill_q + 10'd1;
		end else begin
			wr_en   = (state_q == soa_pkg::ST_FREE) && free_ok;
			wr_addr = base + AW'(idx_in_q[IW-1:0]);
			wr_data = head_q[s_q];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			chain_mem[wr_addr] <= wr_data;
		end
		if (state_q == soa_pkg::ST_READ) begin
			rdata_q <= chain_mem[rd_addr];
		end
	end

	// Slot selection helpers.
	logic [SW+3:0] s_wide;
	logic [SW+3:0] slot_in_wide;
	logic [9:0]    used_inc;
	assign s_wide = {4'd0, s_q};
	assign slot_in_wide = {{SW{1'b0}}, s_tdata[3:0]};
	assign used_inc = used + 10'd1;

	logic in_acc, out_load;
	assign s_tready = (state_q == soa_pkg::ST_IDLE) && !finish_q;
	assign in_acc = s_tvalid && s_tready;
	assign out_load = finish_q && (!out_valid_q || m_tready);
	assign cfg_ready = 1'b1;

	// Chain heads carry no reset.
	always_ff @(posedge clk) begin
		if (state_q == soa_pkg::ST_FILL && fill_q == n - 10'd1) begin
			head_q[s_q] <= 10'd0;
		end else if (state_q == soa_pkg::ST_UPD) begin
			head_q[s_q] <= rdata_q;
		end else if (state_q == soa_pkg::ST_FREE && free_ok) begin
			head_q[s_q] <= {1'b0, idx_in_q};
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == soa_pkg::ST_COLOUR || state_q == soa_pkg::ST_UPD) begin
			prod_q <= mul_p;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			objs_q      <= 10'd8;
			osize_q     <= 13'd32;
			ccount_q    <= 7'd0;
			cstep_q     <= 13'd16;
			for (int i = 0; i < SLAB_SLOTS; i++) begin
				used_q[i]   <= 10'd0;
				class_q[i]  <= soa_pkg::CLS_UNUSED;
				lstamp_q[i] <= 16'd0;
				coff_q[i]   <= 18'd0;
			end
			stamp_q     <= 16'd0;
			ncolour_q   <= 7'd0;
			active_q    <= 14'd0;
			state_q     <= soa_pkg::ST_IDLE;
			cmd_q       <= soa_pkg::CMD_NOP;
			k_q         <= '0;
			s_q         <= '0;
			bad_slot_q  <= 1'b0;
			idx_in_q    <= 9'd0;
			fresh_q     <= 1'b0;
			pfound_q    <= 1'b0;
			efound_q    <= 1'b0;
			ufound_q    <= 1'b0;
			pslot_q     <= '0;
			eslot_q     <= '0;
			uslot_q     <= '0;
			page_q      <= 16'd0;
			eage_q      <= 16'd0;
			fill_q      <= 10'd0;
			rem_q       <= 10'd0;
			res_sts_q   <= soa_pkg::STS_OK;
			res_slot_q  <= 4'd0;
			res_idx_q   <= 9'd0;
			res_off_q   <= 22'd0;
			res_rel_q   <= 5'd0;
			finish_q    <= 1'b0;
			out_valid_q <= 1'b0;
			out_sts_q   <= soa_pkg::STS_OK;
			out_data_q  <= 54'd0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					soa_pkg::REG_OBJECTS_PER_SLAB: objs_q   <= cfg_data[9:0];
					soa_pkg::REG_OBJECT_SIZE:      osize_q  <= cfg_data;
					soa_pkg::REG_COLOUR_COUNT:     ccount_q <= cfg_data[6:0];
					soa_pkg::REG_COLOUR_STEP:      cstep_q  <= cfg_data;
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
				out_sts_q   <= res_sts_q;
				out_data_q  <= {active_q, res_rel_q, res_off_q, res_idx_q, res_slot_q};
				finish_q    <= 1'b0;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				soa_pkg::ST_IDLE: begin
					if (in_acc) begin
						cmd_q      <= soa_pkg::cmd_t'(s_tuser);
						s_q        <= slot_in_wide[SW-1:0];
						bad_slot_q <= {5'd0, s_tdata[3:0]} >= SLOTS_W;
						idx_in_q   <= s_tdata[12:4];
						k_q        <= '0;
						fresh_q    <= 1'b0;
						pfound_q   <= 1'b0;
						efound_q   <= 1'b0;
						ufound_q   <= 1'b0;
						res_sts_q  <= soa_pkg::STS_OK;
						res_slot_q <= 4'd0;
						res_idx_q  <= 9'd0;
						res_off_q  <= 22'd0;
						res_rel_q  <= 5'd0;
						unique case (soa_pkg::cmd_t'(s_tuser))
							soa_pkg::CMD_ALLOC:  state_q <= soa_pkg::ST_SCAN;
							soa_pkg::CMD_FREE:   state_q <= soa_pkg::ST_FREE;
							soa_pkg::CMD_SHRINK: state_q <= soa_pkg::ST_SHRINK;
							default:             finish_q <= 1'b1;
						endcase
					end
				end
				soa_pkg::ST_SCAN: begin
					if (cls == soa_pkg::CLS_PARTIAL && used < n && (!pfound_q || cmp_lt)) begin
						pfound_q <= 1'b1;
						pslot_q  <= k_q;
						page_q   <= age;
					end
					if (cls == soa_pkg::CLS_EMPTY && (!efound_q || cmp_lt)) begin
						efound_q <= 1'b1;
						eslot_q  <= k_q;
						eage_q   <= age;
					end
					if (cls == soa_pkg::CLS_UNUSED && !ufound_q) begin
						ufound_q <= 1'b1;
						uslot_q  <= k_q;
					end
					if (k_q == LAST_SLOT) begin
						state_q <= soa_pkg::ST_PICK;
					end else begin
						k_q <= k_q + SW'(1);
					end
				end
				soa_pkg::ST_PICK: begin
					if (pfound_q) begin
						s_q     <= pslot_q;
						state_q <= soa_pkg::ST_LOADR;
					end else if (efound_q) begin
						s_q     <= eslot_q;
						state_q <= soa_pkg::ST_LOADR;
					end else if (ufound_q) begin
						s_q     <= uslot_q;
						fresh_q <= 1'b1;
						state_q <= soa_pkg::ST_COLOUR;
					end else begin
						res_sts_q <= soa_pkg::STS_NO_SLOT;
						finish_q  <= 1'b1;
						state_q   <= soa_pkg::ST_IDLE;
					end
				end
				soa_pkg::ST_COLOUR: begin
					state_q <= soa_pkg::ST_SETOFF;
				end
				soa_pkg::ST_SETOFF: begin
					coff_q[s_q] <= prod_q[17:0];
					if (ncolour_q + 7'd1 >= ccount_q) begin
						ncolour_q <= 7'd0;
					end else begin
						ncolour_q <= ncolour_q + 7'd1;
					end
					used_q[s_q] <= 10'd0;
					fill_q      <= 10'd0;
					state_q     <= soa_pkg::ST_FILL;
				end
				soa_pkg::ST_FILL: begin
					if (fill_q == n - 10'd1) begin
						state_q <= soa_pkg::ST_LOADR;
					end else begin
						fill_q <= fill_q + 10'd1;
					end
				end
				soa_pkg::ST_LOADR: begin
					// Only the chain end marker lies at or above MAX_OBJECTS, and
					// it reduces to a fixed object index.
					if (head_q[s_q] >= 10'(MAX_OBJECTS)) begin
						rem_q <= END_IDX;
					end else begin
						rem_q <= head_q[s_q];
					end
					state_q <= soa_pkg::ST_READ;
				end
				soa_pkg::ST_READ: begin
					state_q <= soa_pkg::ST_UPD;
				end
				soa_pkg::ST_UPD: begin
					used_q[s_q] <= used_inc;
					if (used_inc >= n) begin
						class_q[s_q]  <= soa_pkg::CLS_FULL;
						lstamp_q[s_q] <= stamp_q;
						stamp_q       <= stamp_q + 16'd1;
					end else if (fresh_q || cls == soa_pkg::CLS_EMPTY) begin
						class_q[s_q]  <= soa_pkg::CLS_PARTIAL;
						lstamp_q[s_q] <= stamp_q;
						stamp_q       <= stamp_q + 16'd1;
					end
					active_q   <= active_q + 14'd1;
					res_slot_q <= s_wide[3:0];
					res_idx_q  <= rem_q[8:0];
					state_q    <= soa_pkg::ST_OFFS;
				end
				soa_pkg::ST_OFFS: begin
					res_off_q <= {4'd0, coff_q[s_q]} + prod_q;
					finish_q  <= 1'b1;
					state_q   <= soa_pkg::ST_IDLE;
				end
				soa_pkg::ST_FREE: begin
					if (free_ok) begin
						used_q[s_q] <= used - 10'd1;
						if (used == 10'd1) begin
							class_q[s_q]  <= soa_pkg::CLS_EMPTY;
							lstamp_q[s_q] <= stamp_q;
							stamp_q       <= stamp_q + 16'd1;
						end else if (cls == soa_pkg::CLS_FULL) begin
							class_q[s_q]  <= soa_pkg::CLS_PARTIAL;
							lstamp_q[s_q] <= stamp_q;
							stamp_q       <= stamp_q + 16'd1;
						end
						if (active_q != 14'd0) begin
							active_q <= active_q - 14'd1;
						end
					end else begin
						res_sts_q <= soa_pkg::STS_NOT_FOUND;
					end
					finish_q <= 1'b1;
					state_q  <= soa_pkg::ST_IDLE;
				end
				soa_pkg::ST_SHRINK: begin
					if (cls == soa_pkg::CLS_EMPTY) begin
						class_q[k_q] <= soa_pkg::CLS_UNUSED;
						used_q[k_q]  <= 10'd0;
						res_rel_q    <= res_rel_q + 5'd1;
					end
					if (k_q == LAST_SLOT) begin
						finish_q <= 1'b1;
						state_q  <= soa_pkg::ST_IDLE;
					end else begin
						k_q <= k_q + SW'(1);
					end
				end
				default: state_q <= soa_pkg::ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_sts_q;
	assign m_tdata  = {2'd0, out_data_q};

	// An accepted command always starts the sequencer or raises a result.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q != soa_pkg::ST_IDLE || finish_q))
		else $error("accepted command did not start");

	// A new result only appears after one was finished.
	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(finish_q))
		else $error("result appeared without a finished command");

	// Chain build never runs past the slab size.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == soa_pkg::ST_FILL |-> fill_q < n)
		else $error("chain fill index past slab size");

	// The reduced chain head is a valid object index before the read.
	a_mod_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == soa_pkg::ST_READ |-> {10'd0, rem_q} < MAX_W)
		else $error("chain head not reduced below object limit");

endmodule

// ===== verif/tb_slab_object_allocator.sv =====
// ----------------------------------------------------------------------------
// Slab object allocator testbench
// Drives allocate, free, shrink and idle commands into the command stream,
// predicts every result with a behavioral slab pool of its own and checks
// every field of each result transaction, under random source gaps, random
// sink stalls and one long sink hold-off.
// ----------------------------------------------------------------------------
module tb_slab_object_allocator;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS    = 16;
	localparam int MAX_OBJ  = 512;
	localparam int CYCLE_LIMIT = 4000000;

	// One predicted or observed result transaction.
	typedef struct packed {
		soa_pkg::status_t status;
		logic [3:0]  slot;
		logic [8:0]  index;
		logic [21:0] offset;
		logic [4:0]  released;
		logic [13:0] active;
	} slab_result_t;

	// An object believed to be allocated, kept so that frees mostly hit.
	typedef struct packed {
		logic [3:0] slot;
		logic [8:0] index;
	} object_ref_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [12:0] cfg_data;

	slab_object_allocator i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Shadow of the allocator state, updated as each command transaction is
	// accepted, so the expected results come out in acceptance order.
	logic [9:0]  chain_link [SLOTS][MAX_OBJ];
	logic [9:0]  head_of [SLOTS];
	logic [9:0]  in_use [SLOTS];
	soa_pkg::slab_class_t class_of [SLOTS];
	logic [15:0] stamp_of [SLOTS];
	logic [17:0] slab_coff [SLOTS];
	logic [15:0] stamp_now;
	logic [6:0]  colour_ptr;
	logic [13:0] live_total;
	logic [9:0]  reg_objects;
	logic [12:0] reg_obj_size;
	logic [6:0]  reg_colours;
	logic [12:0] reg_colour_step;

	slab_result_t pending_results[$];
	object_ref_t  live_objects[$];
	int           mismatches;
	int           items_sent;
	int           burst_left;
	int           hold_off;
	int unsigned  cycle_count;

	// ------------------------------------------------------------------------
	// Clock, reset and run limit.
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Predictor.
	// ------------------------------------------------------------------------
	function automatic int unsigned objects_now();
		if (reg_objects == 0) return 1;
		if (reg_objects > MAX_OBJ) return MAX_OBJ;
		return reg_objects;
	endfunction

	task automatic relist(int s, soa_pkg::slab_class_t c);
		class_of[s] = c;
		stamp_of[s] = stamp_now;
		stamp_now = stamp_now + 16'd1;
	endtask

	// Newest listed slab of a class; the lowest slot wins a tie in age.
	function automatic int newest_slab(soa_pkg::slab_class_t c, int unsigned n,
	                                   bit need_room);
		int best;
		logic [15:0] best_age;
		logic [15:0] age;
		best = -1;
		best_age = '0;
		for (int s = 0; s < SLOTS; s++) begin
			if (class_of[s] != c) continue;
			if (need_room && in_use[s] >= n) continue;
			age = stamp_now - stamp_of[s];
			if (best < 0 || age < best_age) begin
				best = s;
				best_age = age;
			end
		end
		return best;
	endfunction

	task automatic predict_command(input soa_pkg::cmd_t c, input logic [3:0] sl,
	                               input logic [8:0] ix, output slab_result_t r);
		int unsigned n;
		int s;
		bit fresh;
		soa_pkg::slab_class_t was;
		int unsigned idx;
		int unsigned released;
		n = objects_now();
		r = '0;
		r.status = soa_pkg::STS_OK;
		case (c)
			soa_pkg::CMD_ALLOC: begin
				fresh = 0;
				s = newest_slab(soa_pkg::CLS_PARTIAL, n, 1);
				if (s < 0) s = newest_slab(soa_pkg::CLS_EMPTY, n, 0);
				if (s < 0) begin
					for (int k = 0; k < SLOTS; k++)
						if (s < 0 && class_of[k] == soa_pkg::CLS_UNUSED) s = k;
					if (s >= 0) begin
						// A new slab takes the next colour and a chain 0..N-1.
						fresh = 1;
						slab_coff[s] = 18'(colour_ptr) * 18'(reg_colour_step);
						colour_ptr = colour_ptr + 7'd1;
						if (colour_ptr >= reg_colours) colour_ptr = '0;
						for (int unsigned i = 0; i + 1 < n; i++)
							chain_link[s][i] = 10'(i + 1);
						chain_link[s][n - 1] = soa_pkg::CHAIN_END;
						head_of[s] = '0;
						in_use[s] = '0;
					end
				end
				if (s < 0) begin
					r.status = soa_pkg::STS_NO_SLOT;
				end else begin
					idx = head_of[s] % MAX_OBJ;
					was = class_of[s];
					head_of[s] = chain_link[s][idx];
					in_use[s] = in_use[s] + 10'd1;
					if (in_use[s] >= n) relist(s, soa_pkg::CLS_FULL);
					else if (fresh || was == soa_pkg::CLS_EMPTY)
						relist(s, soa_pkg::CLS_PARTIAL);
					live_total = live_total + 14'd1;
					r.slot = 4'(s);
					r.index = 9'(idx);
					r.offset = 22'(slab_coff[s] + idx * reg_obj_size);
					live_objects.push_back({4'(s), 9'(idx)});
				end
			end
			soa_pkg::CMD_FREE: begin
				if (class_of[sl] == soa_pkg::CLS_UNUSED || ix >= n || in_use[sl] == 0) begin
					r.status = soa_pkg::STS_NOT_FOUND;
				end else begin
					// A repeated free is not caught: the index is pushed again.
					chain_link[sl][ix] = head_of[sl];
					head_of[sl] = 10'(ix);
					in_use[sl] = in_use[sl] - 10'd1;
					if (in_use[sl] == 0) relist(sl, soa_pkg::CLS_EMPTY);
					else if (class_of[sl] == soa_pkg::CLS_FULL)
						relist(sl, soa_pkg::CLS_PARTIAL);
					if (live_total > 0) live_total = live_total - 14'd1;
				end
			end
			soa_pkg::CMD_SHRINK: begin
				released = 0;
				for (int k = 0; k < SLOTS; k++)
					if (class_of[k] == soa_pkg::CLS_EMPTY) begin
						class_of[k] = soa_pkg::CLS_UNUSED;
						in_use[k] = '0;
						released++;
					end
				r.released = 5'(released);
			end
			default: ;
		endcase
		r.active = live_total;
	endtask

	// ------------------------------------------------------------------------
	// Source side: one command per call, in bursts separated by random gaps.
	// Every call starts and ends on a falling edge.
	// ------------------------------------------------------------------------
	task automatic send_command(input soa_pkg::cmd_t c, input logic [3:0] sl,
	                            input logic [8:0] ix);
		slab_result_t r;
		if (burst_left == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 40) : $urandom_range(0, 3))
				@(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
			                                         : $urandom_range(1, 8);
		end
		s_tvalid = 1'b1;
		s_tdata = {3'b000, ix, sl};
		s_tuser = c;
		do @(posedge clk); while (!s_tready);
		predict_command(c, sl, ix, r);
		pending_results.push_back(r);
		items_sent++;
		burst_left--;
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	// Waits until every expected result has come back and the block has
	// settled.
	task automatic wait_idle();
		while (pending_results.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_register(input soa_pkg::reg_index_t idx, input logic [12:0] value);
		wait_idle();
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			soa_pkg::REG_OBJECTS_PER_SLAB: reg_objects = value[9:0];
			soa_pkg::REG_OBJECT_SIZE:      reg_obj_size = value;
			soa_pkg::REG_COLOUR_COUNT:     reg_colours = value[6:0];
			soa_pkg::REG_COLOUR_STEP:      reg_colour_step = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic configure(input logic [12:0] objects, input logic [12:0] size,
	                         input logic [12:0] colours, input logic [12:0] step);
		write_register(soa_pkg::REG_OBJECTS_PER_SLAB, objects);
		write_register(soa_pkg::REG_OBJECT_SIZE, size);
		write_register(soa_pkg::REG_COLOUR_COUNT, colours);
		write_register(soa_pkg::REG_COLOUR_STEP, step);
	endtask

	// Frees everything still counted and shrinks, so that every slot is unused
	// again. The object count may only be raised from that state, because a
	// larger count would walk chain links that were never written.
	task automatic release_all();
		for (int s = 0; s < SLOTS; s++)
			while (in_use[s] != 0)
				send_command(soa_pkg::CMD_FREE, 4'(s),
				             9'($urandom_range(0, objects_now() - 1)));
		send_command(soa_pkg::CMD_SHRINK, 4'($urandom), 9'($urandom));
		live_objects.delete();
	endtask

	// ------------------------------------------------------------------------
	// Sink side: a stall pattern that changes now and then, plus an optional
	// long hold-off counted here.
	// ------------------------------------------------------------------------
	initial begin
		int mode;
		int left;
		m_tready = 1'b0;
		mode = 0;
		left = 0;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(20, 200);
			end
			left--;
			if (hold_off > 0) begin
				hold_off--;
				m_tready = 1'b0;
			end else begin
				case (mode)
					0: m_tready = 1'b1;
					1: m_tready = ($urandom_range(0, 3) != 0);
					2: m_tready = ($urandom_range(0, 1) != 0);
					default: m_tready = ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result checker.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		slab_result_t got;
		slab_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.status = soa_pkg::status_t'(m_tuser);
			got.slot = m_tdata[3:0];
			got.index = m_tdata[12:4];
			got.offset = m_tdata[34:13];
			got.released = m_tdata[39:35];
			got.active = m_tdata[53:40];
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction: %p", got);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch at %0t: expected %p, actual %p",
						         $realtime, want, got);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------------

	// Default registers: a few allocations, frees, an idle command and a shrink.
	task automatic test_defaults();
		repeat (3) send_command(soa_pkg::CMD_ALLOC, '0, '0);
		send_command(soa_pkg::CMD_FREE, 4'd0, 9'd1);
		send_command(soa_pkg::CMD_ALLOC, '0, '0);
		send_command(soa_pkg::CMD_NOP, 4'hF, 9'h1FF);
		release_all();
	endtask

	// Rejected frees and a repeated free.
	task automatic test_free_rejects();
		send_command(soa_pkg::CMD_FREE, 4'd9, 9'd0);          // slot never used
		send_command(soa_pkg::CMD_ALLOC, '0, '0);
		send_command(soa_pkg::CMD_FREE, 4'd0, 9'd8);          // index past the slab
		send_command(soa_pkg::CMD_FREE, 4'd0, 9'h1FF);
		send_command(soa_pkg::CMD_ALLOC, '0, '0);
		send_command(soa_pkg::CMD_FREE, 4'd0, 9'd0);
		send_command(soa_pkg::CMD_FREE, 4'd0, 9'd0);          // repeated free
		send_command(soa_pkg::CMD_FREE, 4'd0, 9'd1);          // count already zero
		send_command(soa_pkg::CMD_ALLOC, '0, '0);             // reuses the empty slab
		release_all();
	endtask

	// One object per slab: every slot fills, then no slot is left. Colour count
	// 64 and step 4096, so every new slab gets its own colour.
	task automatic test_pool_exhaustion();
		configure(13'd0, 13'h1FFF, 13'd64, 13'd4096);
		repeat (SLOTS + 1) send_command(soa_pkg::CMD_ALLOC, '0, '0);
		send_command(soa_pkg::CMD_FREE, 4'd15, 9'd0);         // full slab becomes empty
		send_command(soa_pkg::CMD_ALLOC, '0, '0);
		release_all();
	endtask

	// Largest slab and the largest object index.
	task automatic test_largest_slab();
		configure(13'd1023, 13'd4096, 13'd127, 13'h1FFF);
		repeat (2) send_command(soa_pkg::CMD_ALLOC, '0, '0);
		send_command(soa_pkg::CMD_FREE, 4'd0, 9'd511);        // unallocated, pushed anyway
		send_command(soa_pkg::CMD_ALLOC, '0, '0);
		release_all();
	endtask

	// Lowering the object count leaves a partial slab that is now too full.
	task automatic test_lowered_count();
		configure(13'd8, 13'd16, 13'd3, 13'd1);
		repeat (5) send_command(soa_pkg::CMD_ALLOC, '0, '0);
		write_register(soa_pkg::REG_OBJECTS_PER_SLAB, 13'd3);
		repeat (2) send_command(soa_pkg::CMD_ALLOC, '0, '0);
		release_all();
	endtask

	// The sink holds off long enough for the block to stop taking commands.
	task automatic test_backpressure();
		configure(13'd4, 13'd48, 13'd5, 13'd64);
		wait_idle();
		hold_off = 400;
		repeat (24)
			send_command($urandom_range(0, 2) == 0 ? soa_pkg::CMD_FREE : soa_pkg::CMD_ALLOC,
			             4'($urandom_range(0, 3)), 9'($urandom_range(0, 3)));
		release_all();
	endtask

	// Random phases, each with its own registers.
	task automatic test_random(int target);
		int phase_len;
		int pick;
		int n;
		object_ref_t obj;
		while (items_sent < target) begin
			pick = $urandom_range(0, 19);
			configure(pick == 0 ? 13'd0 : pick == 1 ? 13'd512 : pick == 2 ? 13'h3FF
			                    : 13'($urandom_range(1, 12)),
			          13'($urandom), 13'($urandom_range(0, 127)), 13'($urandom));
			n = objects_now();
			phase_len = (n > 64) ? $urandom_range(10, 30) : $urandom_range(40, 120);
			repeat (phase_len) begin
				pick = $urandom_range(0, 99);
				if (pick < 48) begin
					send_command(soa_pkg::CMD_ALLOC, 4'($urandom), 9'($urandom));
				end else if (pick < 83 && live_objects.size() != 0) begin
					n = $urandom_range(0, live_objects.size() - 1);
					obj = live_objects[n];
					live_objects.delete(n);
					send_command(soa_pkg::CMD_FREE, obj.slot, obj.index);
				end else if (pick < 91) begin
					send_command(soa_pkg::CMD_FREE, 4'($urandom), $urandom_range(0, 1)
					             ? 9'($urandom) : 9'($urandom_range(0, objects_now() - 1)));
				end else if (pick < 97) begin
					send_command(soa_pkg::CMD_SHRINK, 4'($urandom), 9'($urandom));
				end else begin
					send_command(soa_pkg::CMD_NOP, 4'($urandom), 9'($urandom));
				end
			end
			release_all();
		end
	endtask

	// ------------------------------------------------------------------------
	// Sequence.
	// ------------------------------------------------------------------------
	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		mismatches = 0;
		items_sent = 0;
		burst_left = 0;
		hold_off = 0;
		cycle_count = 0;
		for (int s = 0; s < SLOTS; s++) begin
			in_use[s] = '0;
			head_of[s] = '0;
			class_of[s] = soa_pkg::CLS_UNUSED;
			stamp_of[s] = '0;
			slab_coff[s] = '0;
		end
		stamp_now = '0;
		colour_ptr = '0;
		live_total = '0;
		reg_objects = 10'd8;
		reg_obj_size = 13'd32;
		reg_colours = 7'd0;
		reg_colour_step = 13'd16;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (4) @(negedge clk);

		test_defaults();
		test_free_rejects();
		test_pool_exhaustion();
		test_largest_slab();
		test_lowered_count();
		test_backpressure();
		test_random(items_sent + 600);

		while (pending_results.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
